/* sv/assert_macros.svh */
// Assertion shorthands shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that is checked at every clock edge outside reset.
`define TLBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define TLBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tlbp_pkg.sv */
package tlbp_pkg;

  // Address width of pc and targets.
  localparam int ADDR_W = 64;

  // Default sizes of the tables.
  localparam int HISTORY_BITS_DEF   = 8;
  localparam int ROW_BITS_DEF       = 3;
  localparam int BUFFER_ENTRIES_DEF = 128;
  localparam int TAG_BITS_DEF       = 16;

  // Two-bit saturating counter values.
  localparam logic [1:0] CTR_INIT = 2'd2;
  localparam logic [1:0] CTR_MAX  = 2'd3;
  localparam logic [1:0] CTR_MIN  = 2'd0;

  // Distance to the fall-through instruction.
  localparam logic [ADDR_W-1:0] FALL_STEP = 64'd4;

  // Request codes.
  localparam logic REQ_PREDICT = 1'b0;
  localparam logic REQ_UPDATE  = 1'b1;

  // Commands from the sequencer to the pattern table.
  typedef struct packed {
    logic lookup;
    logic train;
    logic jump;
  } pht_cmd_t;

  // Commands from the sequencer to the target buffer.
  typedef struct packed {
    logic start;
    logic is_update;
  } btb_cmd_t;

  // Response of the target buffer; done is a one-cycle pulse.
  typedef struct packed {
    logic done;
    logic hit;
  } btb_rsp_t;

  // Saturating step of a two-bit counter toward taken or not taken.
  function automatic logic [1:0] ctr_train(input logic [1:0] ctr, input logic up);
    logic [1:0] res;
    res = ctr;
    if (up) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

/* sv/tlbp_pht.sv */
module tlbp_pht #(
  parameter int HISTORY_BITS = tlbp_pkg::HISTORY_BITS_DEF,
  parameter int ROW_BITS     = tlbp_pkg::ROW_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tlbp_pkg::pht_cmd_t   cmd,
  input  logic [ROW_BITS-1:0]  row,
  output logic                 ready,
  output logic [1:0]           ctr
);

  localparam int IDX_W = HISTORY_BITS + ROW_BITS;
  localparam int DEPTH = 1 << IDX_W;

  logic [1:0]              mem [DEPTH];
  logic [HISTORY_BITS-1:0] history;
  logic [HISTORY_BITS:0]   hist_shift;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        rd_addr;
  logic                    clearing;
  logic [IDX_W-1:0]        clr_idx;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [1:0]              wr_data;

  // Column from the global history, row from the pc.
  assign rd_addr    = {history, row};
  assign hist_shift = {history, cmd.jump};
  assign ready      = !clearing;

  // The clearing sweep owns the write port until every counter is weakly taken.
  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
      wr_data = tlbp_pkg::CTR_INIT;
    end else begin
      wr_en   = cmd.train;
      wr_addr = idx;
      wr_data = tlbp_pkg::ctr_train(ctr, cmd.jump);
    end
  end

  // Clearing sweep and global history.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
      history  <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + IDX_W'(1);
        if (clr_idx == '1) clearing <= 1'b0;
      end
      if (cmd.train) history <= hist_shift[HISTORY_BITS-1:0];
    end
  end

  // Counter memory. The index of a lookup is kept so that training writes
  // back to the same counter, trained at the history that selected it.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.lookup) begin
      ctr <= mem[rd_addr];
      idx <= rd_addr;
    end
  end

endmodule

/* sv/tlbp_btb.sv */
module tlbp_btb #(
  parameter int BUFFER_ENTRIES = tlbp_pkg::BUFFER_ENTRIES_DEF,
  parameter int TAG_BITS       = tlbp_pkg::TAG_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tlbp_pkg::btb_cmd_t   cmd,
  input  logic [TAG_BITS-1:0]  tag,
  input  logic [TAG_BITS-1:0]  new_target,
  output tlbp_pkg::btb_rsp_t   rsp,
  output logic [TAG_BITS-1:0]  hit_target
);

  localparam int IDX_W = $clog2(BUFFER_ENTRIES);
  localparam int CNT_W = $clog2(BUFFER_ENTRIES + 1);

  typedef enum logic {B_IDLE, B_SCAN} bstate_t;

  bstate_t                 state;
  logic [2*TAG_BITS-1:0]   mem [BUFFER_ENTRIES];
  logic [2*TAG_BITS-1:0]   rdata;
  logic [IDX_W-1:0]        check_idx;
  logic [CNT_W-1:0]        fill;
  logic [IDX_W-1:0]        ins_ptr;
  logic                    is_upd;
  logic [TAG_BITS-1:0]     entry_tag;
  logic [TAG_BITS-1:0]     entry_tgt;
  logic                    match;
  logic                    last;
  logic                    empty;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    ins;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;

  assign entry_tag = rdata[2*TAG_BITS-1:TAG_BITS];
  assign entry_tgt = rdata[TAG_BITS-1:0];
  assign match     = (state == B_SCAN) && (entry_tag == tag);
  assign last      = (CNT_W'(check_idx) + CNT_W'(1)) == fill;
  assign empty     = (fill == '0);

  // Scan addresses run one ahead of the entry being compared. The tag and
  // new target inputs are held by the sequencer for the whole search.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    ins     = 1'b0;
    wr_en   = 1'b0;
    unique case (state)
      B_IDLE: begin
        rd_en = cmd.start && !empty;
        ins   = cmd.start && empty && cmd.is_update;
        wr_en = ins;
      end
      B_SCAN: begin
        rd_en   = !match && !last;
        rd_addr = check_idx + IDX_W'(1);
        ins     = is_upd && !match && last;
        wr_en   = is_upd && (match || last);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
    wr_addr = ins ? ins_ptr : check_idx;
  end

  // Search sequencing, fill count and FIFO insert pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      fill     <= '0;
      ins_ptr  <= '0;
      rsp.done <= 1'b0;
      rsp.hit  <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (cmd.start) begin
            if (empty) begin
              rsp.done <= 1'b1;
              rsp.hit  <= 1'b0;
            end else begin
              state <= B_SCAN;
            end
          end
        end
        B_SCAN: begin
          if (match) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b1;
            state    <= B_IDLE;
          end else if (last) begin
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b0;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
      if (ins) begin
        ins_ptr <= (ins_ptr == IDX_W'(BUFFER_ENTRIES - 1)) ? '0 : ins_ptr + IDX_W'(1);
        if (fill != CNT_W'(BUFFER_ENTRIES)) fill <= fill + CNT_W'(1);
      end
    end
  end

  // Scan position, request kind and the target of the first match.
  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      check_idx <= '0;
      if (cmd.start) is_upd <= cmd.is_update;
    end else if (!match && !last) begin
      check_idx <= check_idx + IDX_W'(1);
    end
    if (match) hit_target <= entry_tgt;
  end

  // Buffer memory, each entry {tag, target}.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {tag, new_target};
    if (rd_en) rdata <= mem[rd_addr];
  end

endmodule

/* sv/two_level_branch_predictor_btb.sv */
// Channel  Handshake            Fields
// input    in_valid / in_stall  req_type, pc, resolved_target
// output   out_valid / out_stall predicted_target, predicted_taken, buffer_hit
//
// A request not taken (predict) or not jumping (update) ends after the counter
// memory read and, for an update, its write back. A taken predict or jumping
// update searches the target buffer one entry a cycle, from index 0 up to the
// first match or through the fill count on a miss; an empty buffer is not searched.
// After reset a sweep over all 2^(HISTORY_BITS+ROW_BITS) counters (2048 by
// default) sets each one; in_stall stays high meanwhile. A waiting result sits
// in the output register, so a stalled output holds the block only when a
// second predict result is ready.
module two_level_branch_predictor_btb #(
  parameter int HISTORY_BITS   = tlbp_pkg::HISTORY_BITS_DEF,
  parameter int ROW_BITS       = tlbp_pkg::ROW_BITS_DEF,
  parameter int BUFFER_ENTRIES = tlbp_pkg::BUFFER_ENTRIES_DEF,
  parameter int TAG_BITS       = tlbp_pkg::TAG_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [tlbp_pkg::ADDR_W-1:0] pc,
  input  logic [tlbp_pkg::ADDR_W-1:0] resolved_target,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tlbp_pkg::ADDR_W-1:0] predicted_target,
  output logic                        predicted_taken,
  output logic                        buffer_hit
);

  localparam int AW = tlbp_pkg::ADDR_W;

  typedef enum logic [1:0] {S_IDLE, S_CTR, S_BTB, S_EMIT} state_t;

  state_t             state;
  logic               is_upd_q;
  logic [AW-1:0]      pc_q;
  logic [AW-1:0]      tgt_q;
  logic [AW-1:0]      res_target;
  logic               res_taken;
  logic               res_hit;
  logic               pht_ready;
  logic [1:0]         pht_ctr;
  tlbp_pkg::pht_cmd_t pht_cmd;
  tlbp_pkg::btb_cmd_t btb_cmd;
  tlbp_pkg::btb_rsp_t btb_rsp;
  logic [TAG_BITS-1:0] hit_target;
  logic               accept;
  logic               out_free;
  logic [AW-1:0]      fall;
  logic               jump;
  logic               taken;
  logic               fin;
  logic               fin_taken;
  logic               fin_hit;
  logic [AW-1:0]      fin_target;

  assign in_stall = (state != S_IDLE) || !pht_ready;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Fall-through address and the taken decisions.
  assign fall  = pc_q + tlbp_pkg::FALL_STEP;
  assign jump  = (tgt_q != fall);
  assign taken = pht_ctr[1];

  // Commands to the counter table and the target buffer.
  always_comb begin
    pht_cmd.lookup    = accept;
    pht_cmd.train     = (state == S_CTR) && is_upd_q;
    pht_cmd.jump      = jump;
    btb_cmd.start     = (state == S_CTR) && (is_upd_q ? jump : taken);
    btb_cmd.is_update = is_upd_q;
  end

  // Result of a predict that completes in this cycle.
  always_comb begin
    fin = ((state == S_CTR) && !is_upd_q && !taken) ||
          ((state == S_BTB) && btb_rsp.done && !is_upd_q);
    fin_taken  = (state == S_BTB);
    fin_hit    = (state == S_BTB) && btb_rsp.hit;
    fin_target = fin_hit ? {pc_q[AW-1:TAG_BITS], hit_target} : fall;
  end

  tlbp_pht #(
    .HISTORY_BITS (HISTORY_BITS),
    .ROW_BITS     (ROW_BITS)
  ) u_pht (
    .clk   (clk),
    .rst   (rst),
    .cmd   (pht_cmd),
    .row   (pc[ROW_BITS+1:2]),
    .ready (pht_ready),
    .ctr   (pht_ctr)
  );

  tlbp_btb #(
    .BUFFER_ENTRIES (BUFFER_ENTRIES),
    .TAG_BITS       (TAG_BITS)
  ) u_btb (
    .clk        (clk),
    .rst        (rst),
    .cmd        (btb_cmd),
    .tag        (pc_q[TAG_BITS-1:0]),
    .new_target (tgt_q[TAG_BITS-1:0]),
    .rsp        (btb_rsp),
    .hit_target (hit_target)
  );

  // Request sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            is_upd_q <= (req_type == tlbp_pkg::REQ_UPDATE);
            pc_q     <= pc;
            tgt_q    <= resolved_target;
            state    <= S_CTR;
          end
        end
        S_CTR: begin
          if (is_upd_q) begin
            state <= jump ? S_BTB : S_IDLE;
          end else if (taken) begin
            state <= S_BTB;
          end else begin
            state <= out_free ? S_IDLE : S_EMIT;
          end
        end
        S_BTB: begin
          if (btb_rsp.done) begin
            if (is_upd_q) state <= S_IDLE;
            else          state <= out_free ? S_IDLE : S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      // The output register takes a finished predict or the held result,
      // and otherwise empties on a transfer.
      if (fin && out_free) begin
        out_valid        <= 1'b1;
        predicted_target <= fin_target;
        predicted_taken  <= fin_taken;
        buffer_hit       <= fin_hit;
      end else if ((state == S_EMIT) && out_free) begin
        out_valid        <= 1'b1;
        predicted_target <= res_target;
        predicted_taken  <= res_taken;
        buffer_hit       <= res_hit;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // A finished predict that cannot go out waits in the result holder.
      if (fin && !out_free) begin
        res_target <= fin_target;
        res_taken  <= fin_taken;
        res_hit    <= fin_hit;
      end
    end
  end

endmodule

/* sv/tlbp_checker.sv */
`include "assert_macros.svh"

module tlbp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic req_type,
  input logic out_valid,
  input logic predicted_taken,
  input logic buffer_hit
);

  // A buffer hit is only reported for a taken prediction.
  `TLBP_ASSERT(a_hit_needs_taken, out_valid |-> (!buffer_hit || predicted_taken), "buffer hit without taken")

  // One request at a time: the block is busy right after a transfer in.
  `TLBP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted two requests back to back")

  // An update never produces a result.
  `TLBP_ASSERT_NEXT(a_update_silent, in_valid && !in_stall && (req_type == tlbp_pkg::REQ_UPDATE), !$rose(out_valid), "result after an update")

  // The counter sweep holds off requests right after reset.
  `TLBP_ASSERT(a_stall_after_reset, $past(rst) |-> in_stall, "request taken during the counter sweep")

endmodule

bind two_level_branch_predictor_btb tlbp_checker u_tlbp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .req_type        (req_type),
  .out_valid       (out_valid),
  .predicted_taken (predicted_taken),
  .buffer_hit      (buffer_hit)
);

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int IDX_W = tlbp_pkg::HISTORY_BITS_DEF + tlbp_pkg::ROW_BITS_DEF;
  localparam int TAG_W = tlbp_pkg::TAG_BITS_DEF;
  localparam int SLOTS = tlbp_pkg::BUFFER_ENTRIES_DEF;
  localparam int AW = tlbp_pkg::ADDR_W;
  localparam int POOL = 192;
  localparam int HOT = 24;
  localparam int IDLE_PCT = 26;
  localparam int TAIL_CYCLES = 200;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic          req;
    logic [AW-1:0] pc;
    logic [AW-1:0] dst;
  } branch_req_t;

  typedef struct packed {
    logic [AW-1:0] target;
    logic          taken;
    logic          hit;
  } guess_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic          req_type;
  logic [AW-1:0] pc;
  logic [AW-1:0] resolved_target;
  logic          out_valid;
  logic          out_stall;
  logic [AW-1:0] predicted_target;
  logic          predicted_taken;
  logic          buffer_hit;

  two_level_branch_predictor_btb i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .pc               (pc),
    .resolved_target  (resolved_target),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .predicted_target (predicted_target),
    .predicted_taken  (predicted_taken),
    .buffer_hit       (buffer_hit)
  );

  // Mirror of the predictor state.
  logic [1:0]       ctr_tbl [0:(1<<IDX_W)-1];
  logic [7:0]       ghist;
  logic [TAG_W-1:0] btb_tag [0:SLOTS-1];
  logic [TAG_W-1:0] btb_dst [0:SLOTS-1];
  int               btb_fill;
  int               btb_next;

  branch_req_t branch_reqs[$];
  guess_t      pending_predictions[$];
  branch_req_t next_req;
  guess_t      want;
  logic [AW-1:0] hot_pc  [0:POOL-1];
  logic [AW-1:0] hot_dst [0:POOL-1];

  bit req_sent;
  bit calm;
  int errors;
  int cycles;

  function automatic logic [AW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Lowest-index valid entry whose tag matches, or -1.
  function automatic int btb_lookup(input logic [TAG_W-1:0] tag);
    int i;
    for (i = 0; i < btb_fill; i++) begin
      if (btb_tag[i] == tag) return i;
    end
    return -1;
  endfunction

  // Applies one accepted request to the mirror; a predict queues its answer.
  task automatic predict_branch(input branch_req_t r);
    logic [IDX_W-1:0] idx;
    logic [1:0]       ctr;
    logic [AW-1:0]    fall;
    logic             jump;
    guess_t           g;
    int               e;
    idx  = {ghist, r.pc[tlbp_pkg::ROW_BITS_DEF+1:2]};
    ctr  = ctr_tbl[idx];
    fall = r.pc + tlbp_pkg::FALL_STEP;
    if (r.req == tlbp_pkg::REQ_PREDICT) begin
      g.target = fall;
      g.taken  = ctr[1];
      g.hit    = 1'b0;
      if (ctr[1]) begin
        e = btb_lookup(r.pc[TAG_W-1:0]);
        if (e >= 0) begin
          g.hit    = 1'b1;
          g.target = {r.pc[AW-1:TAG_W], btb_dst[e]};
        end
      end
      pending_predictions.push_back(g);
    end else begin
      // Train at the old history, then shift, then write the buffer.
      jump = (r.dst != fall);
      if (jump) begin
        if (ctr != tlbp_pkg::CTR_MAX) ctr = ctr + 2'd1;
      end else begin
        if (ctr != tlbp_pkg::CTR_MIN) ctr = ctr - 2'd1;
      end
      ctr_tbl[idx] = ctr;
      ghist = {ghist[6:0], jump};
      if (jump) begin
        e = btb_lookup(r.pc[TAG_W-1:0]);
        if (e >= 0) begin
          btb_dst[e] = r.dst[TAG_W-1:0];
        end else begin
          btb_tag[btb_next] = r.pc[TAG_W-1:0];
          btb_dst[btb_next] = r.dst[TAG_W-1:0];
          btb_next = (btb_next + 1) % SLOTS;
          if (btb_fill < SLOTS) btb_fill++;
        end
      end
    end
  endtask

  task automatic queue_req(input logic r, input logic [AW-1:0] p, input logic [AW-1:0] t);
    branch_reqs.push_back('{req: r, pc: p, dst: t});
  endtask

  // Mostly resolve-then-fetch episodes on a pool of branches, plus noise.
  task automatic queue_branch_mix(input int count);
    int made;
    int roll;
    int k;
    logic [AW-1:0] d;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(99);
      k = ($urandom_range(99) < 70) ? $urandom_range(HOT - 1) : $urandom_range(POOL - 1);
      if (roll < 70) begin
        if ($urandom_range(99) < 25) begin
          d = hot_pc[k] + tlbp_pkg::FALL_STEP;
        end else if ($urandom_range(99) < 15) begin
          d = rand64();
          hot_dst[k] = d;
        end else begin
          d = hot_dst[k];
        end
        queue_req(tlbp_pkg::REQ_UPDATE, hot_pc[k], d);
        queue_req(tlbp_pkg::REQ_PREDICT, hot_pc[k], rand64());
        made += 2;
      end else if (roll < 85) begin
        queue_req(tlbp_pkg::REQ_PREDICT, hot_pc[k], rand64());
        made++;
      end else begin
        queue_req($urandom_range(1) ? tlbp_pkg::REQ_UPDATE : tlbp_pkg::REQ_PREDICT,
                  rand64(), rand64());
        made++;
      end
    end
  endtask

  // Holds the sender until every queued request is in and answered.
  task automatic drain_all();
    while (branch_reqs.size() != 0 || in_valid || pending_predictions.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  // Input driver: a new request is presented only after the last transfer.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_sent) begin
      req_sent = 1'b0;
      if (branch_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_req = branch_reqs.pop_front();
        in_valid        <= 1'b1;
        req_type        <= next_req.req;
        pc              <= next_req.pc;
        resolved_target <= next_req.dst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: mirror each input transfer and check each output transfer.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_branch('{req: req_type, pc: pc, dst: resolved_target});
      req_sent = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_predictions.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result target=%h taken=%b hit=%b",
                   $time, predicted_target, predicted_taken, buffer_hit);
      end else begin
        want = pending_predictions.pop_front();
        if (predicted_target !== want.target) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: predicted_target expected %h actual %h",
                     $time, want.target, predicted_target);
        end
        if (predicted_taken !== want.taken) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: predicted_taken expected %b actual %b",
                     $time, want.taken, predicted_taken);
        end
        if (buffer_hit !== want.hit) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: buffer_hit expected %b actual %b", $time, want.hit, buffer_hit);
        end
      end
    end
  end

  // Stimulus and end of test.
  initial begin
    int i;
    rst             = 1'b1;
    in_valid        = 1'b0;
    out_stall       = 1'b0;
    req_type        = tlbp_pkg::REQ_PREDICT;
    pc              = '0;
    resolved_target = '0;
    req_sent        = 1'b0;
    calm            = 1'b0;
    errors          = 0;
    cycles          = 0;
    for (i = 0; i < (1 << IDX_W); i++) ctr_tbl[i] = tlbp_pkg::CTR_INIT;
    for (i = 0; i < SLOTS; i++) begin
      btb_tag[i] = '0;
      btb_dst[i] = '0;
    end
    ghist    = '0;
    btb_fill = 0;
    btb_next = 0;

    // Branch pool; every eighth entry aliases the tag of its neighbor.
    for (i = 0; i < POOL; i++) begin
      hot_pc[i]  = rand64();
      hot_dst[i] = rand64();
      if (i % 8 == 7) hot_pc[i][TAG_W-1:0] = hot_pc[i-1][TAG_W-1:0];
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: address extremes, fall-through wrap, both saturation ends,
    // buffer insert, rewrite by an aliased tag, and hit with foreign upper bits.
    queue_req(tlbp_pkg::REQ_PREDICT, 64'h0, 64'h0);
    queue_req(tlbp_pkg::REQ_PREDICT, '1, '1);
    queue_req(tlbp_pkg::REQ_PREDICT, 64'hFFFF_FFFF_FFFF_FFFC, 64'h0);
    queue_req(tlbp_pkg::REQ_UPDATE, 64'hFFFF_FFFF_FFFF_FFFC, 64'h0);
    repeat (3) queue_req(tlbp_pkg::REQ_UPDATE, 64'h1000, 64'h1004);
    queue_req(tlbp_pkg::REQ_PREDICT, 64'h1000, 64'h0);
    repeat (10) queue_req(tlbp_pkg::REQ_UPDATE, 64'h2000, '1);
    queue_req(tlbp_pkg::REQ_UPDATE, 64'h8000_0000_0000_2000, 64'h0);
    queue_req(tlbp_pkg::REQ_PREDICT, 64'h2000, '1);
    queue_req(tlbp_pkg::REQ_PREDICT, 64'hFFFF_FFFF_FFFF_2000, 64'h0);
    queue_req(tlbp_pkg::REQ_PREDICT, 64'h2004, 64'h0);
    drain_all();

    // Random traffic; the middle stretch runs with no idling on either side.
    queue_branch_mix(700);
    drain_all();
    calm = 1'b1;
    queue_branch_mix(450);
    drain_all();
    calm = 1'b0;
    queue_branch_mix(450);
    drain_all();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
